// File: rtl/fqmh_pkg.sv
// Shared constants, payload types, controller types and helpers for the promote FIFO.
package fqmh_pkg;

  localparam int DEPTH  = 16;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ENQ     = 3'd0;
  localparam logic [OP_W-1:0] OP_DEQ     = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
  localparam logic [OP_W-1:0] OP_SIZE    = 3'd3;
  localparam logic [OP_W-1:0] OP_PROMOTE = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_ATHEAD = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] value;
  } fqmh_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] head_value;
    logic [CNT_W-1:0]         entry_count;
    logic [ST_W-1:0]          status;
  } fqmh_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SCAN_END,
    S_CHECK,
    S_SHIFT,
    S_SHIFT_END,
    S_PUT_MAX,
    S_HEAD_RD,
    S_LOAD
  } fqmh_state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;       // capture the input item
    logic exec;        // apply enqueue / dequeue and set status
    logic scan_rd;     // read next position of the maximum scan
    logic set_athead;  // maximum already at head
    logic shift_init;  // start the shift just below the maximum
    logic shift_rd;    // read next position of the shift
    logic put_max;     // write the maximum to the head slot
    logic load_out;    // load the result register
  } fqmh_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic promote_go;  // promote on a non-empty queue
    logic scan_last;   // scan reads the last occupied position
    logic best_zero;   // maximum sits at the head
    logic shift_last;  // shift reads position zero
    logic out_busy;    // result register still waits to be taken
  } fqmh_stat_t;

  // Physical slot of logical position pos counted from head
  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                               input logic [PTR_W-1:0] pos);
    logic [PTR_W:0] sum;
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= (PTR_W+1)'(DEPTH)) begin
      sum = sum - (PTR_W+1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

// File: rtl/fifo_queue_move_max_to_head.sv
// Bounded FIFO of signed words with a promote operation that moves the
// latest largest entry to the head. One item is taken at a time: enqueue,
// dequeue, peek, size and unused codes pass through the execute, head-read
// and load steps. Promote on a non-empty queue first scans the entries with
// a one-entry-per-cycle scan of the single-read-port slot memory; unless the
// maximum already sits at the head, a one-entry-per-cycle shift then moves
// the entries ahead of it down by one and the maximum is written to the head
// slot. The next item can be accepted in the cycle after the result is
// loaded. The result sits in an output register, so the next item is
// accepted while the previous result waits; a result still waiting stalls
// the following one in its load step.
module fifo_queue_move_max_to_head import fqmh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  fqmh_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output fqmh_out_t out_data
);

  fqmh_cmd_t  cmd;
  fqmh_stat_t stat;

  fqmh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fqmh_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/fqmh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fqmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/fqmh_ctrl.sv
// Sequencing state machine for the promote FIFO.
module fqmh_ctrl import fqmh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  fqmh_stat_t stat,
  output fqmh_cmd_t  cmd
);

  fqmh_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.promote_go ? S_SCAN : S_HEAD_RD;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.best_zero) begin
          cmd.set_athead = 1'b1;
          state_next     = S_HEAD_RD;
        end else begin
          cmd.shift_init = 1'b1;
          state_next     = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift_rd = 1'b1;
        if (stat.shift_last) begin
          state_next = S_SHIFT_END;
        end
      end
      S_SHIFT_END: begin
        state_next = S_PUT_MAX;
      end
      S_PUT_MAX: begin
        cmd.put_max = 1'b1;
        state_next  = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/fqmh_dp.sv
// Datapath: pointers, scan and shift registers, slot memory and result register.
module fqmh_dp import fqmh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  fqmh_in_t   in_data,
  input  fqmh_cmd_t  cmd,
  output fqmh_stat_t stat,
  output logic       out_valid,
  input  logic       out_ready,
  output fqmh_out_t  out_data
);

  logic [OP_W-1:0]          op;
  logic [DATA_W-1:0]        val;
  logic [PTR_W-1:0]         head_ptr;
  logic [CNT_W-1:0]         occupancy;
  logic [ST_W-1:0]          status;
  logic [PTR_W-1:0]         pos;
  logic                     cmp_vld;
  logic                     cmp_first;
  logic [PTR_W-1:0]         cmp_pos;
  logic                     shf_vld;
  logic [PTR_W-1:0]         shf_pos;
  logic [PTR_W-1:0]         best;
  logic signed [DATA_W-1:0] bval;

  logic                     we;
  logic [PTR_W-1:0]         waddr;
  logic [DATA_W-1:0]        wdata;
  logic [PTR_W-1:0]         raddr;
  logic [DATA_W-1:0]        rdata;
  logic                     is_empty;
  logic                     is_full;

  assign is_empty = (occupancy == '0);
  assign is_full  = (occupancy == CNT_W'(DEPTH));

  // Status toward the controller
  assign stat.promote_go = (op == OP_PROMOTE) && !is_empty;
  assign stat.scan_last  = (CNT_W'(pos) + 1'b1 == occupancy);
  assign stat.best_zero  = (best == '0);
  assign stat.shift_last = (pos == '0);
  assign stat.out_busy   = out_valid && !out_ready;

  // Select memory write and read
  always_comb begin
    we    = 1'b0;
    waddr = head_ptr;
    wdata = val;
    raddr = head_ptr;
    if (cmd.exec && op == OP_ENQ && !is_full) begin
      we    = 1'b1;
      waddr = slot_of(head_ptr, occupancy[PTR_W-1:0]);
    end else if (shf_vld) begin
      we    = 1'b1;
      waddr = slot_of(head_ptr, shf_pos + 1'b1);
      wdata = rdata;
    end else if (cmd.put_max) begin
      we    = 1'b1;
      wdata = bval;
    end
    if (cmd.scan_rd || cmd.shift_rd) begin
      raddr = slot_of(head_ptr, pos);
    end
  end

  fqmh_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr  <= '0;
      occupancy <= '0;
    end else if (cmd.exec) begin
      case (op)
        OP_ENQ: begin
          if (!is_full) begin
            occupancy <= occupancy + 1'b1;
          end
        end
        OP_DEQ: begin
          if (!is_empty) begin
            occupancy <= occupancy - 1'b1;
            head_ptr  <= (occupancy == CNT_W'(1)) ? '0 : slot_of(head_ptr, PTR_W'(1));
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the item and the status of the current operation
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op  <= in_data.opcode;
      val <= in_data.value;
    end
    if (cmd.exec) begin
      case (op)
        OP_ENQ:     status <= is_full  ? ST_FULL  : ST_OK;
        OP_DEQ:     status <= is_empty ? ST_EMPTY : ST_OK;
        OP_PEEK:    status <= is_empty ? ST_EMPTY : ST_OK;
        OP_PROMOTE: status <= is_empty ? ST_EMPTY : ST_OK;
        default:    status <= ST_OK;
      endcase
    end else if (cmd.set_athead) begin
      status <= ST_ATHEAD;
    end
  end

  // Advance the scan and shift position
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pos <= '0;
    end else if (cmd.scan_rd) begin
      pos <= pos + 1'b1;
    end else if (cmd.shift_init) begin
      pos <= best - 1'b1;
    end else if (cmd.shift_rd) begin
      pos <= pos - 1'b1;
    end
  end

  // Track read data returning from the memory
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
      shf_vld <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan_rd;
      shf_vld <= cmd.shift_rd;
    end
    cmp_first <= (pos == '0);
    cmp_pos   <= pos;
    shf_pos   <= pos;
  end

  // Keep the latest largest value; ties go to the later entry
  always_ff @(posedge clk) begin
    if (cmp_vld && (cmp_first || $signed(rdata) >= bval)) begin
      bval <= $signed(rdata);
      best <= cmp_pos;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.head_value  <= is_empty ? '0 : $signed(rdata);
      out_data.entry_count <= occupancy;
      out_data.status      <= status;
    end
  end

endmodule

// File: rtl/fqmh_checker.sv
// Port-level checks for the promote FIFO and their binding to the top level.
module fqmh_checker import fqmh_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input fqmh_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input fqmh_out_t out_data
);

  // A waiting input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input item changed while waiting");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Empty status only with no entries
  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_EMPTY |-> out_data.entry_count == '0)
    else $error("empty status with entries held");

  // Full status only at capacity
  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_FULL |-> out_data.entry_count == CNT_W'(DEPTH))
    else $error("full status below capacity");

  // Empty queue reports a zero head
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.entry_count == '0 |-> out_data.head_value == '0)
    else $error("nonzero head on empty queue");

endmodule

bind fifo_queue_move_max_to_head fqmh_checker u_fqmh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: dv/fqmh_tb_pkg.sv
// Scoreboard for the promote FIFO: queue image, result prediction and result checks.
`timescale 1ns / 1ps
package fqmh_tb_pkg;
  import fqmh_pkg::*;

  class fifo_scoreboard;
    // logical view of the stored words, index 0 is the head
    logic signed [DATA_W-1:0] queue_image[$];
    fqmh_out_t                pending_results[$];
    int                       errors;

    function new();
      errors = 0;
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t ns: %s", $realtime, msg);
      errors++;
    endtask

    // Apply one operation to the queue image and queue the result it causes
    function void note_item(fqmh_in_t item);
      fqmh_out_t                res;
      logic signed [DATA_W-1:0] best_val;
      int                       best_pos;
      res.status = ST_OK;
      case (item.opcode)
        OP_ENQ: begin
          if (queue_image.size() >= DEPTH) begin
            res.status = ST_FULL;
          end else begin
            queue_image.push_back(item.value);
          end
        end
        OP_DEQ: begin
          if (queue_image.size() == 0) begin
            res.status = ST_EMPTY;
          end else begin
            void'(queue_image.pop_front());
          end
        end
        OP_PEEK: begin
          if (queue_image.size() == 0) begin
            res.status = ST_EMPTY;
          end
        end
        OP_PROMOTE: begin
          if (queue_image.size() == 0) begin
            res.status = ST_EMPTY;
          end else begin
            // latest among equal maxima wins
            best_pos = 0;
            for (int p = 1; p < queue_image.size(); p++) begin
              if (queue_image[p] >= queue_image[best_pos]) begin
                best_pos = p;
              end
            end
            if (best_pos == 0) begin
              res.status = ST_ATHEAD;
            end else begin
              best_val = queue_image[best_pos];
              queue_image.delete(best_pos);
              queue_image.push_front(best_val);
            end
          end
        end
        default: begin
          // size and spare codes leave the queue as it is
        end
      endcase
      res.head_value  = (queue_image.size() != 0) ? queue_image[0] : '0;
      res.entry_count = CNT_W'(queue_image.size());
      pending_results.push_back(res);
    endfunction

    // Compare one accepted result with the oldest prediction
    task check_result(fqmh_out_t got);
      fqmh_out_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result head=%0d count=%0d status=%0d",
                                  got.head_value, got.entry_count, got.status));
      end else begin
        want = pending_results.pop_front();
        if (got.head_value !== want.head_value) begin
          report_mismatch($sformatf("head_value got %0d want %0d",
                                    got.head_value, want.head_value));
        end
        if (got.entry_count !== want.entry_count) begin
          report_mismatch($sformatf("entry_count got %0d want %0d",
                                    got.entry_count, want.entry_count));
        end
        if (got.status !== want.status) begin
          report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
        end
      end
    endtask
  endclass

endpackage

// File: dv/tb.sv
// Top-level testbench for the promote FIFO: clock, reset, stimulus and result monitor.
`timescale 1ns / 1ps
module tb;
  import fqmh_pkg::*;
  import fqmh_tb_pkg::*;

  localparam int              CLK_HALF       = 10;
  localparam int              ITEMS_PER_PASS = 400;
  localparam int              END_SLACK      = 2 * DEPTH + 20;
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  fqmh_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  fqmh_out_t out_data;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;

  fifo_scoreboard sb = new();

  fifo_queue_move_max_to_head i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // Stall the result side at random
  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= receiver_stall_pct);
  end

  // Track both handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.note_item(in_data);
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
      end
    end
  end

  // Offer one item, with random idle cycles ahead of it; returns at a falling edge
  task send_item(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_data.opcode <= op;
    in_data.value  <= val;
    do begin
      @(posedge clk);
    end while (!in_ready);
    @(negedge clk);
  endtask

  // Hold off until every predicted result has arrived; returns at a later falling edge
  task wait_drained();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (sb.pending_count() != 0);
  endtask

  // Mix of extremes, small clustered values for ties, and full-range words
  function logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(7);
    case (r)
      0:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      1:       return $urandom_range(1) ? 32'sd0 : -32'sd1;
      2, 3:    return $signed($urandom_range(8)) - 32'sd4;
      default: return $urandom;
    endcase
  endfunction

  // Pick an operation, leaning toward growth or shrinkage
  function logic [OP_W-1:0] pick_opcode(bit filling);
    int r;
    r = $urandom_range(99);
    if (r < 4)  return 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
    if (r < 10) return OP_PEEK;
    if (r < 15) return OP_SIZE;
    if (r < 35) return OP_PROMOTE;
    if (r < 70) return filling ? OP_ENQ : OP_DEQ;
    return filling ? OP_DEQ : OP_ENQ;
  endfunction

  task run_pass(int n, int idle_pct, int stall_pct);
    bit filling;
    int run_left;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    filling  = 1'b1;
    run_left = $urandom_range(60, 20);
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        filling  = !filling;
        run_left = $urandom_range(60, 20);
      end
      run_left--;
      send_item(pick_opcode(filling), pick_value());
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty queue errors, size and spare codes when empty
    send_item(OP_PEEK, 32'sd0);
    send_item(OP_DEQ, 32'sd0);
    send_item(OP_PROMOTE, 32'sd0);
    send_item(OP_SIZE, 32'sd0);
    send_item(OP_SPARE_FIRST, 32'sd0);
    send_item(OP_SPARE_LAST, -32'sd1);
    // promote on a single entry, then ties between maxima
    send_item(OP_ENQ, 32'sh80000000);
    send_item(OP_PROMOTE, 32'sd0);
    send_item(OP_ENQ, 32'sh7fffffff);
    send_item(OP_ENQ, 32'sh7fffffff);
    send_item(OP_PROMOTE, 32'sd0);
    send_item(OP_PROMOTE, 32'sd0);
    send_item(OP_ENQ, -32'sd1);
    // fill up, then overflow and spare code at full
    for (int i = 0; i < DEPTH - 4; i++) begin
      send_item(OP_ENQ, $urandom);
    end
    send_item(OP_ENQ, 32'sd0);
    send_item(OP_ENQ, 32'sd5);
    send_item(OP_SPARE_FIRST + 3'd1, 32'sd0);
    send_item(OP_PROMOTE, 32'sd0);
    send_item(OP_DEQ, 32'sd0);
    wait_drained();

    // Random passes with different idle patterns
    run_pass(ITEMS_PER_PASS, 0, 0);
    run_pass(ITEMS_PER_PASS, 47, 0);
    run_pass(ITEMS_PER_PASS, 0, 47);
    run_pass(ITEMS_PER_PASS, 20, 20);

    repeat (END_SLACK) @(negedge clk);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/fqmh_pkg.sv
rtl/fqmh_ram.sv
rtl/fqmh_ctrl.sv
rtl/fqmh_dp.sv
rtl/fifo_queue_move_max_to_head.sv
rtl/fqmh_checker.sv
dv/fqmh_tb_pkg.sv
dv/tb.sv
